// File: design/short_run_removal_filter_defines.svh
// ----------------------------------------------------------------------------
// Short run removal filter: assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHORT_RUN_REMOVAL_FILTER_DEFINES_SVH
`define SHORT_RUN_REMOVAL_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define SRRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srrf assertion failed");
// Expression must never be true outside reset
`define SRRF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("srrf forbidden condition seen");
`else
`define SRRF_ASSERT(lbl, prop)
`define SRRF_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: design/srrf_pkg.sv
// ----------------------------------------------------------------------------
// Short run removal filter: package
// Shared widths, register indexes and the types passed between the parts.
// ----------------------------------------------------------------------------
package srrf_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned RunCntW  = 6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxValue   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMinRun1 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxMinRun2 = 2'd2;

  // Configuration as seen by both passes
  typedef struct packed {
    logic                value;
    logic [CfgDataW-1:0] min_run1;
    logic [CfgDataW-1:0] min_run2;
  } cfg_t;

  // Run of first-pass flags: len copies of flag; last marks end of sequence
  typedef struct packed {
    logic               flag;
    logic [RunCntW-1:0] len;
    logic               last;
  } cmd_t;

  // Saturate a minimum run length at the build limit
  function automatic logic [RunCntW-1:0] clamp_min(input logic [CfgDataW-1:0] m,
                                                   input logic [CfgDataW-1:0] max_run);
    return (m > max_run) ? RunCntW'(max_run) : RunCntW'(m);
  endfunction

endpackage

// File: design/srrf_intf.sv
// ----------------------------------------------------------------------------
// Short run removal filter: stream interfaces
// Valid/ready channels for raw flags in and cleaned flags out.
// ----------------------------------------------------------------------------
interface srrf_in_if;
  logic valid;
  logic ready;
  logic flag_in;
  logic last_in;

  modport source (output valid, output flag_in, output last_in, input ready);
  modport sink   (input valid, input flag_in, input last_in, output ready);
endinterface

interface srrf_out_if;
  logic valid;
  logic ready;
  logic flag_out;
  logic last_out;

  modport source (output valid, output flag_out, output last_out, input ready);
  modport sink   (input valid, input flag_out, input last_out, output ready);
endinterface

// File: design/short_run_removal_filter.sv
// ----------------------------------------------------------------------------
// Short run removal filter: top level
// Two cascaded minimum run length passes on a stream of silence flags.
// ----------------------------------------------------------------------------
// The first pass takes one flag per cycle whenever its two-entry command queue
// has room and folds it into a run command; the second pass walks each command
// one flag per cycle while its burst counter is free, and loads released runs into
// an output burst counter that sends one cleaned flag per cycle while the output is
// ready. Throughput is set by the second pass; the first pass keeps taking flags
// while the second still walks earlier commands, until the command queue fills.
// Config writes take effect on the next item; the user must make them only while
// idle, as the block itself does not enforce it.
module short_run_removal_filter #(
  parameter int unsigned MAX_RUN = 31
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  srrf_in_if.sink                            in_if,
  srrf_out_if.source                         out_if,
  input  logic                               cfg_we_i,
  input  logic [srrf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [srrf_pkg::CfgDataW-1:0]      cfg_data_i
);
  import srrf_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value    <= 1'b1;
      cfg_q.min_run1 <= '0;
      cfg_q.min_run2 <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxValue:   cfg_q.value    <= cfg_data_i[0];
        CfgIdxMinRun1: cfg_q.min_run1 <= cfg_data_i;
        CfgIdxMinRun2: cfg_q.min_run2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srrf_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_if.valid),
    .in_flag_i  (in_if.flag_in),
    .in_last_i  (in_if.last_in),
    .in_ready_o (in_if.ready),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  srrf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  srrf_back #(
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (empty),
    .fifo_cmd_i   (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_flag_o   (out_if.flag_out),
    .out_last_o   (out_if.last_out)
  );

endmodule

// File: design/srrf_front.sv
// ----------------------------------------------------------------------------
// Short run removal filter: first pass
// Accepts one raw flag per cycle while the command queue has room and turns it into at most one run command.
// ----------------------------------------------------------------------------
module srrf_front #(
  parameter int unsigned MAX_RUN = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srrf_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  input  logic           in_flag_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  logic           full_i,
  output logic           push_o,
  output srrf_pkg::cmd_t cmd_o
);
  import srrf_pkg::*;

  localparam logic [CfgDataW-1:0] MaxRunC = CfgDataW'(MAX_RUN);

  logic [RunCntW-1:0] cnt_q, cnt_d, cnt_inc, min_run;
  logic               com_q, com_d;
  logic               fire;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && !full_i;
  assign min_run    = clamp_min(cfg_i.min_run1, MaxRunC);
  assign cnt_inc    = cnt_q + RunCntW'(1);

  // Classify the item against the held run
  always_comb begin
    cnt_d      = cnt_q;
    com_d      = com_q;
    push_o     = 1'b0;
    cmd_o.flag = in_flag_i;
    cmd_o.len  = cnt_inc;
    cmd_o.last = in_last_i;
    if (fire) begin
      if (in_flag_i == cfg_i.value) begin
        if (com_q) begin
          // committed run passes straight through
          push_o    = 1'b1;
          cmd_o.len = RunCntW'(1);
          com_d     = !in_last_i;
        end else if (cnt_inc >= min_run) begin
          // run just got long enough: release it unchanged
          push_o = 1'b1;
          cnt_d  = '0;
          com_d  = !in_last_i;
        end else if (in_last_i) begin
          // short run cut by end of sequence: release flipped
          push_o     = 1'b1;
          cmd_o.flag = !cfg_i.value;
          cnt_d      = '0;
          com_d      = 1'b0;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        // held short run flips to this flag's value, then the flag itself
        push_o = 1'b1;
        cnt_d  = '0;
        com_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      com_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      com_q <= com_d;
    end
  end

endmodule

// File: design/srrf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Short run removal filter: command queue
// Two-entry queue of run commands between the first and second pass.
// ----------------------------------------------------------------------------
module srrf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srrf_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output srrf_pkg::cmd_t cmd_o
);
  import srrf_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: design/srrf_back.sv
// ----------------------------------------------------------------------------
// Short run removal filter: second pass and output
// Walks run commands one flag per cycle while the burst emitter is free, and emits released bursts.
// ----------------------------------------------------------------------------
`include "short_run_removal_filter_defines.svh"

module srrf_back #(
  parameter int unsigned MAX_RUN = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srrf_pkg::cfg_t cfg_i,
  input  logic           fifo_empty_i,
  input  srrf_pkg::cmd_t fifo_cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_flag_o,
  output logic           out_last_o
);
  import srrf_pkg::*;

  localparam logic [CfgDataW-1:0] MaxRunC = CfgDataW'(MAX_RUN);

  // current command
  cmd_t               cmd_q, cmd_d;
  logic               cmd_act_q, cmd_act_d;
  // second-pass run state
  logic [RunCntW-1:0] cnt_q, cnt_d, cnt_inc, min_run;
  logic               com_q, com_d;
  // burst emitter
  logic               em_flag_q, em_flag_d, em_last_q, em_last_d;
  logic [RunCntW-1:0] em_rem_q, em_rem_d;
  logic               em_act_q, em_act_d;

  logic               v2, em_free, step, final_flag, last_of_cmd, out_fire;
  logic               burst, b_flag;
  logic [RunCntW-1:0] b_len;

  assign v2          = !cfg_i.value;
  assign min_run     = clamp_min(cfg_i.min_run2, MaxRunC);
  assign cnt_inc     = cnt_q + RunCntW'(1);
  assign out_fire    = em_act_q && out_ready_i;
  assign em_free     = !em_act_q || (out_ready_i && em_rem_q == RunCntW'(1));
  assign step        = cmd_act_q && em_free;
  assign last_of_cmd = (cmd_q.len == RunCntW'(1));
  assign final_flag  = cmd_q.last && last_of_cmd;
  assign pop_o       = !fifo_empty_i && (!cmd_act_q || (step && last_of_cmd));

  assign out_valid_o = em_act_q;
  assign out_flag_o  = em_flag_q;
  assign out_last_o  = em_last_q && (em_rem_q == RunCntW'(1));

  // Second pass on one flag of the current command
  always_comb begin
    cnt_d  = cnt_q;
    com_d  = com_q;
    burst  = 1'b0;
    b_flag = cmd_q.flag;
    b_len  = cnt_inc;
    if (step) begin
      if (cmd_q.flag == v2) begin
        if (com_q) begin
          burst = 1'b1;
          b_len = RunCntW'(1);
        end else if (cnt_inc >= min_run) begin
          burst = 1'b1;
          cnt_d = '0;
          com_d = 1'b1;
        end else if (final_flag) begin
          // short run cut by end of sequence: release flipped
          burst  = 1'b1;
          b_flag = !v2;
          cnt_d  = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        // held short run flips to this flag's value, then the flag itself
        burst = 1'b1;
        cnt_d = '0;
        com_d = 1'b0;
      end
      if (final_flag) begin
        cnt_d = '0;
        com_d = 1'b0;
      end
    end
  end

  // Command register and emitter next state
  always_comb begin
    cmd_d     = cmd_q;
    cmd_act_d = cmd_act_q;
    if (pop_o) begin
      cmd_d     = fifo_cmd_i;
      cmd_act_d = 1'b1;
    end else if (step) begin
      cmd_d.len = cmd_q.len - RunCntW'(1);
      if (last_of_cmd) begin
        cmd_act_d = 1'b0;
      end
    end

    em_flag_d = em_flag_q;
    em_last_d = em_last_q;
    em_rem_d  = em_rem_q;
    em_act_d  = em_act_q;
    if (step && burst) begin
      em_flag_d = b_flag;
      em_last_d = final_flag;
      em_rem_d  = b_len;
      em_act_d  = 1'b1;
    end else if (out_fire) begin
      em_rem_d = em_rem_q - RunCntW'(1);
      if (em_rem_q == RunCntW'(1)) begin
        em_act_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_act_q <= 1'b0;
      cnt_q     <= '0;
      com_q     <= 1'b0;
      em_act_q  <= 1'b0;
      em_rem_q  <= '0;
    end else begin
      cmd_act_q <= cmd_act_d;
      cnt_q     <= cnt_d;
      com_q     <= com_d;
      em_act_q  <= em_act_d;
      em_rem_q  <= em_rem_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    em_flag_q <= em_flag_d;
    em_last_q <= em_last_d;
  end

  `SRRF_ASSERT(a_em_rem_nonzero, em_act_q |-> (em_rem_q != '0))
  `SRRF_ASSERT(a_final_clears, (step && final_flag) |=> (cnt_q == '0 && !com_q && em_act_q && em_last_q))
  `SRRF_ASSERT_NEVER(a_commit_with_count, com_q && (cnt_q != '0))
  `SRRF_ASSERT_NEVER(a_cmd_len_zero, cmd_act_q && (cmd_q.len == '0))

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Short run removal filter: testbench
// Drives raw silence flags through the two-pass filter, random pacing on both
// channels, and checks every cleaned flag in order against an in-bench model
// of both run length passes, over several filter settings including extremes.
// ----------------------------------------------------------------------------
module testbench;
  import srrf_pkg::*;

  localparam int unsigned MaxRun      = 31;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned StallLimit  = 3000;

  typedef struct packed {
    logic flag;
    logic last;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  srrf_in_if  in_if ();
  srrf_out_if out_if ();

  short_run_removal_filter #(
    .MAX_RUN (MaxRun)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  frame_t raw_frames_q[$];
  frame_t cleaned_q[$];
  logic   released_q[$];

  // Filter model state: settings and one held run per pass
  logic                cfg_value;
  logic [CfgDataW-1:0] cfg_min1;
  logic [CfgDataW-1:0] cfg_min2;
  logic [RunCntW-1:0]  run_len[2];
  logic                run_locked[2];

  int     err_cnt;
  int     queued_cnt;
  int     accepted_cnt;
  int     flags_checked;
  int     seq_ends;
  int     settings_used;
  int     idle_cycles;
  int     send_gap;
  int     hold_gap;
  bit     no_idle;
  frame_t next_frame;
  frame_t want;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned sat_min(input logic [CfgDataW-1:0] m);
    return (m > MaxRun) ? MaxRun : int'(m);
  endfunction

  // Push one flag into a pass; released flags go to released_q
  task automatic run_feed(input int p, input logic v, input int unsigned m,
                          input logic f);
    if (f == v) begin
      if (run_locked[p]) begin
        released_q.push_back(v);
      end else begin
        run_len[p] = run_len[p] + 1'b1;
        if (run_len[p] >= m) begin
          repeat (run_len[p]) released_q.push_back(v);
          run_len[p]    = '0;
          run_locked[p] = 1'b1;
        end
      end
    end else begin
      // a held run ended short: it comes out flipped
      repeat (run_len[p]) released_q.push_back(~v);
      run_len[p]    = '0;
      run_locked[p] = 1'b0;
      released_q.push_back(f);
    end
  endtask

  // End of sequence: a held run is short by construction
  task automatic run_flush(input int p, input logic v);
    repeat (run_len[p]) released_q.push_back(~v);
    run_len[p]    = '0;
    run_locked[p] = 1'b0;
  endtask

  // Expected cleaned flags for one accepted raw frame
  task automatic predict_frame(input logic f, input logic last);
    logic        first_out[$];
    int unsigned n;
    released_q.delete();
    run_feed(0, cfg_value, sat_min(cfg_min1), f);
    if (last) run_flush(0, cfg_value);
    first_out = released_q;
    released_q.delete();
    foreach (first_out[i]) run_feed(1, ~cfg_value, sat_min(cfg_min2), first_out[i]);
    if (last) run_flush(1, ~cfg_value);
    n = released_q.size();
    foreach (released_q[i]) cleaned_q.push_back('{flag: released_q[i],
                                                   last: last && (i == n - 1)});
  endtask

  // Driver: one raw frame per handshake, random gaps between frames
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.flag_in <= 1'b0;
      in_if.last_in <= 1'b0;
      send_gap = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (raw_frames_q.size() != 0) begin
        next_frame = raw_frames_q.pop_front();
        in_if.valid   <= 1'b1;
        in_if.flag_in <= next_frame.flag;
        in_if.last_in <= next_frame.last;
        send_gap = no_idle ? 0 : pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on input handshakes, check output handshakes, pace ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_frame(in_if.flag_in, in_if.last_in);
        accepted_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        if (cleaned_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item flag %0b last %0b", $time,
                   out_if.flag_out, out_if.last_out);
        end else begin
          want = cleaned_q.pop_front();
          if (out_if.flag_out !== want.flag) begin
            err_cnt++;
            $display("%0t: flag mismatch, expected %0b got %0b", $time,
                     want.flag, out_if.flag_out);
          end
          if (out_if.last_out !== want.last) begin
            err_cnt++;
            $display("%0t: last mismatch, expected %0b got %0b", $time,
                     want.last, out_if.last_out);
          end
          flags_checked++;
          if (want.last) seq_ends++;
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) hold_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic add_frame(input logic f, input logic last);
    raw_frames_q.push_back('{flag: f, last: last});
    queued_cnt++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  // Only called with the filter idle
  task automatic set_filter(input logic v, input logic [CfgDataW-1:0] m1,
                            input logic [CfgDataW-1:0] m2);
    write_reg(CfgIdxValue, CfgDataW'(v));
    write_reg(CfgIdxMinRun1, m1);
    write_reg(CfgIdxMinRun2, m2);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_value = v;
    cfg_min1  = m1;
    cfg_min2  = m2;
    settings_used++;
  endtask

  // Wait until every frame is in and every cleaned flag is out
  task automatic drain();
    while (accepted_cnt != queued_cnt || cleaned_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Run length aimed at the minimum that applies to this flag value
  function automatic int run_length(input logic f);
    int m;
    int r;
    m = (f == cfg_value) ? int'(cfg_min1) : int'(cfg_min2);
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 3);
    if (r < 75) return ((m < 2) ? 1 : m - 1) + $urandom_range(0, 2);
    return $urandom_range(4, 12);
  endfunction

  // Alternating runs with random lengths; sequence ends now and then
  task automatic queue_runs(input int budget);
    int   n;
    int   len;
    logic f;
    n = 0;
    f = 1'($urandom_range(0, 1));
    while (n < budget) begin
      len = run_length(f);
      for (int k = 0; k < len && n < budget; k++) begin
        n++;
        add_frame(f, (n == budget) || ($urandom_range(0, 24) == 0));
      end
      f = ~f;
    end
  endtask

  initial begin
    int   budget[7] = '{15, 30, 25, 20, 15, 20, 25};
    logic pval[7]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int   pmin1[7]  = '{0, 31, 31, 3, 1, 0, 2};
    int   pmin2[7]  = '{0, 31, 2, 5, 1, 0, 31};

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.flag_in = 1'b0;
    in_if.last_in = 1'b0;
    out_if.ready  = 1'b0;
    err_cnt       = 0;
    queued_cnt    = 0;
    accepted_cnt  = 0;
    flags_checked = 0;
    seq_ends      = 0;
    settings_used = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    // register and run state after reset
    cfg_value     = 1'b1;
    cfg_min1      = '0;
    cfg_min2      = '0;
    run_len[0]    = '0;
    run_len[1]    = '0;
    run_locked[0] = 1'b0;
    run_locked[1] = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: minimum of zero, every flag passes straight through
    @(negedge clk_i);
    add_frame(1'b0, 1'b0); add_frame(1'b1, 1'b0); add_frame(1'b1, 1'b0);
    add_frame(1'b0, 1'b0); add_frame(1'b1, 1'b1);
    drain();

    // Short runs in both passes, a held run cut by the sequence end,
    // and single-frame sequences
    set_filter(1'b1, 5'd3, 5'd2);
    @(negedge clk_i);
    add_frame(1'b1, 1'b0); add_frame(1'b1, 1'b0); add_frame(1'b0, 1'b0);
    add_frame(1'b1, 1'b0); add_frame(1'b1, 1'b0); add_frame(1'b1, 1'b0);
    add_frame(1'b1, 1'b0); add_frame(1'b0, 1'b0); add_frame(1'b1, 1'b0);
    add_frame(1'b0, 1'b0); add_frame(1'b0, 1'b0); add_frame(1'b1, 1'b0);
    add_frame(1'b1, 1'b1); add_frame(1'b1, 1'b1); add_frame(1'b0, 1'b1);
    drain();

    // Random runs under several settings, extremes included
    for (int p = 0; p < 7; p++) begin
      if (p == 5) begin
        set_filter(1'($urandom_range(0, 1)), CfgDataW'($urandom_range(0, 8)),
                   CfgDataW'($urandom_range(0, 8)));
      end else begin
        set_filter(pval[p], CfgDataW'(pmin1[p]), CfgDataW'(pmin2[p]));
      end
      no_idle = (p == 4);
      @(negedge clk_i);
      queue_runs(budget[p]);
      drain();
    end

    $display("Covered %0d raw frames under %0d filter settings;", accepted_cnt,
             settings_used + 1);
    $display("checked %0d cleaned flags across %0d sequence ends.", flags_checked,
             seq_ends);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
